>>> rtl/swfe_pkg.sv
// ----------------------------------------------------------------------------
// swfe_pkg
// Shared types and constants of the sync word frame extractor.
// ----------------------------------------------------------------------------
package swfe_pkg;

    localparam int unsigned SKIP_W = 16;
    localparam int unsigned DIM_W  = 10;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned IDX_W  = 2;

    // First seven bytes of the sync word, oldest in the high byte
    localparam logic [55:0]       SYNC_HEAD = 56'hAAAA4444BBBB77;
    localparam logic [BYTE_W-1:0] SYNC_LAST = 8'h77;
    localparam logic [SKIP_W-1:0] SYNC_LEN  = 16'd8;

    localparam logic [SKIP_W-1:0] SKIP_RESET   = 16'd512;
    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 10'd320;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 10'd240;

    localparam logic [IDX_W-1:0] CFG_SYNC_SKIP    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    typedef struct packed {
        logic [SKIP_W-1:0] sync_skip;
        logic [DIM_W-1:0]  image_width;
        logic [DIM_W-1:0]  image_height;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel;
        logic [DIM_W-1:0]  column;
        logic [DIM_W-1:0]  row;
        logic              frame_end;
    } t_pix;

endpackage

>>> rtl/swfe_byte_if.sv
// ----------------------------------------------------------------------------
// swfe_byte_if
// Raw byte channel from the camera link.
// ----------------------------------------------------------------------------
interface swfe_byte_if;
    logic                         valid;
    logic                         ready;
    logic [swfe_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/swfe_pix_if.sv
// ----------------------------------------------------------------------------
// swfe_pix_if
// Pixel channel carrying payload bytes with their position.
// ----------------------------------------------------------------------------
interface swfe_pix_if;
    logic                         valid;
    logic                         ready;
    logic [swfe_pkg::BYTE_W-1:0]  pixel;
    logic [swfe_pkg::DIM_W-1:0]   column;
    logic [swfe_pkg::DIM_W-1:0]   row;
    logic                         frame_end;

    modport source (output valid, output pixel, output column, output row,
                    output frame_end, input ready);
    modport sink   (input valid, input pixel, input column, input row,
                    input frame_end, output ready);
endinterface

>>> rtl/swfe_cfg_regs.sv
// ----------------------------------------------------------------------------
// swfe_cfg_regs
// Configuration registers: sync skip, image width and image height.
// ----------------------------------------------------------------------------
module swfe_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swfe_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [swfe_pkg::SKIP_W-1:0]  i_cfg_data,
    output swfe_pkg::t_cfg               o_cfg
);

    swfe_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_skip    <= swfe_pkg::SKIP_RESET;
            r_cfg.image_width  <= swfe_pkg::WIDTH_RESET;
            r_cfg.image_height <= swfe_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                swfe_pkg::CFG_SYNC_SKIP: begin
                    r_cfg.sync_skip <= i_cfg_data;
                end
                swfe_pkg::CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[swfe_pkg::DIM_W-1:0];
                end
                swfe_pkg::CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[swfe_pkg::DIM_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/swfe_core.sv
// ----------------------------------------------------------------------------
// swfe_core
// Hunt, skip and payload state with column and row counters.
// ----------------------------------------------------------------------------
module swfe_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  swfe_pkg::t_cfg               i_cfg,
    input  logic                         i_accept,
    input  logic [swfe_pkg::BYTE_W-1:0]  i_byte,
    output logic                         o_emit,
    output swfe_pkg::t_pix               o_pix
);

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_SKIP,
        ST_PAYLOAD
    } t_state;

    t_state                        r_state, n_state;
    logic [55:0]                   r_recent, n_recent;
    logic [swfe_pkg::SKIP_W-1:0]   r_skip, n_skip;
    logic [swfe_pkg::DIM_W-1:0]    r_col, n_col;
    logic [swfe_pkg::DIM_W-1:0]    r_row, n_row;

    logic [swfe_pkg::DIM_W-1:0]    last_col;
    logic [swfe_pkg::DIM_W-1:0]    last_row;
    logic [swfe_pkg::DIM_W-1:0]    cur_col;
    logic [swfe_pkg::DIM_W-1:0]    cur_row;
    logic                          take;
    logic                          row_done;
    logic                          frame_done;

    always_comb begin
        last_col = (i_cfg.image_width == '0) ? '0 : i_cfg.image_width - 1'b1;
        last_row = (i_cfg.image_height == '0) ? '0 : i_cfg.image_height - 1'b1;

        take = (r_state == ST_PAYLOAD) ||
               ((r_state == ST_SKIP) && (r_skip >= i_cfg.sync_skip));

        cur_col    = (r_state == ST_PAYLOAD) ? r_col : '0;
        cur_row    = (r_state == ST_PAYLOAD) ? r_row : '0;
        row_done   = cur_col >= last_col;
        frame_done = row_done && (cur_row >= last_row);

        n_state  = r_state;
        n_recent = r_recent;
        n_skip   = r_skip;
        n_col    = r_col;
        n_row    = r_row;

        if (take) begin
            n_state = ST_PAYLOAD;
            if (frame_done) begin
                n_state  = ST_HUNT;
                n_recent = '0;
                n_skip   = '0;
                n_col    = '0;
                n_row    = '0;
            end else if (row_done) begin
                n_col = '0;
                n_row = cur_row + 1'b1;
            end else begin
                n_col = cur_col + 1'b1;
                n_row = cur_row;
            end
        end else if (r_state == ST_SKIP) begin
            n_skip = r_skip + 1'b1;
        end else if ((r_recent == swfe_pkg::SYNC_HEAD) && (i_byte == swfe_pkg::SYNC_LAST)) begin
            n_state  = ST_SKIP;
            n_recent = '0;
            n_skip   = swfe_pkg::SYNC_LEN;
            n_col    = '0;
            n_row    = '0;
        end else begin
            n_recent = {r_recent[47:0], i_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_HUNT;
            r_recent <= '0;
            r_skip   <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_accept) begin
            r_state  <= n_state;
            r_recent <= n_recent;
            r_skip   <= n_skip;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    assign o_emit          = i_accept && take;
    assign o_pix.pixel     = i_byte;
    assign o_pix.column    = cur_col;
    assign o_pix.row       = cur_row;
    assign o_pix.frame_end = frame_done;

endmodule

>>> rtl/swfe_out_reg.sv
// ----------------------------------------------------------------------------
// swfe_out_reg
// Result register that drives the pixel channel.
// ----------------------------------------------------------------------------
module swfe_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  swfe_pkg::t_pix      i_pix,
    output logic                o_room,
    swfe_pix_if.source          o_out
);

    logic            r_valid;
    swfe_pkg::t_pix  r_pix;

    // Room when empty or the held transaction leaves this cycle
    assign o_room = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_load) begin
            r_pix <= i_pix;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.pixel     = r_pix.pixel;
    assign o_out.column    = r_pix.column;
    assign o_out.row       = r_pix.row;
    assign o_out.frame_end = r_pix.frame_end;

endmodule

>>> rtl/sync_word_frame_extractor.sv
// ----------------------------------------------------------------------------
// sync_word_frame_extractor
// Finds the AA AA 44 44 BB BB 77 77 sync word in a camera byte stream, skips
// to the image start and passes image_width*image_height pixels with their
// column, row and a last-of-frame flag.
// ----------------------------------------------------------------------------
// Usage: one byte is taken per clock, every clock, as long as the pixel
// output is not stalled. A byte runs through the state update in the cycle it
// is offered, and its pixel is valid on the output from the edge that accepts
// the byte. While a pixel waits on a stalled output the input is held,
// whatever the next byte would produce. Sync, skip and hunt bytes produce no
// output. Write sync_skip, image_width and image_height only while the stream
// is idle; zero width or height acts as one.
module sync_word_frame_extractor (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [swfe_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [swfe_pkg::SKIP_W-1:0]  i_cfg_data,
    swfe_byte_if.sink                    i_in,
    swfe_pix_if.source                   o_out
);

    swfe_pkg::t_cfg  cfg;
    swfe_pkg::t_pix  pix;
    logic            room;
    logic            accept;
    logic            emit;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    swfe_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    swfe_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .o_emit   (emit),
        .o_pix    (pix)
    );

    swfe_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_pix   (pix),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
